// ----- rtl/core/pbwv_pkg.sv -----
`timescale 1ns / 1ps

package pbwv_pkg;

  // Parse phase of the record walker
  typedef enum logic [1:0] {
    PH_KEY    = 2'd0,
    PH_VARINT = 2'd1,
    PH_LENGTH = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  // Wire types accepted in a key
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Field number width and register map
  localparam int FIELD_BITS = 29;
  localparam int ADDR_BITS = 2;
  localparam logic [ADDR_BITS-1:0] REG_MAX_FIELD = 2'd0;

  // Varint byte index saturates here
  localparam logic [3:0] IDX_MAX = 4'd15;

endpackage

// ----- rtl/core/pbwv_in_if.sv -----
`timescale 1ns / 1ps

// Record byte channel
interface pbwv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/pbwv_out_if.sv -----
`timescale 1ns / 1ps

// Verdict channel
interface pbwv_out_if;
  logic valid;
  logic ready;
  logic record_ok;

  modport source (output valid, output record_ok, input ready);
  modport sink (input valid, input record_ok, output ready);
endinterface

// ----- rtl/core/protobuf_wire_validator.sv -----
`timescale 1ns / 1ps

// Protobuf wire-format validator. Takes one record byte per beat on rec_in and
// gives one verdict beat on verdict for each byte marked last_byte, registered
// when that byte is taken (record_ok = 1 when every key is well formed and the
// record ends on a payload boundary). Throughput is one byte per clock: each
// byte updates the parse state as it is taken, and the verdict sits in one
// output register, so rec_in stalls only while a verdict waits unread. The
// register max_field_number (byte address 0, reset 2^29-1) may be written only
// while no record is in flight. LENGTH_BITS sets the width of the length-prefix
// counter; longer lengths saturate.
module protobuf_wire_validator
  import pbwv_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  pbwv_in_if.sink              rec_in,
  pbwv_out_if.source           verdict,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int WIDE_W = 7 * 16;

  // Parse state
  phase_t                  phase, phase_next;
  logic [FIELD_BITS-1:0]   key_accum, key_accum_next;
  logic                    key_too_big, key_too_big_next;
  logic [2:0]              wire_type, wire_type_next;
  logic [3:0]              varint_index, varint_index_next;
  logic [LENGTH_BITS-1:0]  length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0]  bytes_left, bytes_left_next;
  logic                    failed, failed_next;
  logic [FIELD_BITS-1:0]   max_field_number;

  // Output register
  logic out_valid;
  logic out_ok;

  logic       in_fire;
  logic [6:0] pay;
  logic       more;
  logic       key_ended;
  logic       ok_now;
  logic [3:0] idx_inc;
  logic [6:0] len_shift;
  logic [WIDE_W-1:0] len_wide;
  logic       len_over;
  logic [LENGTH_BITS-1:0] len_new;
  logic [LENGTH_BITS-1:0] left_dec;

  assign in_fire = rec_in.valid && rec_in.ready;
  assign rec_in.ready = !out_valid || verdict.ready;
  assign verdict.valid = out_valid;
  assign verdict.record_ok = out_ok;

  assign pay  = rec_in.data_byte[6:0];
  assign more = rec_in.data_byte[7];
  assign idx_inc = (varint_index != IDX_MAX) ? varint_index + 4'd1 : varint_index;

  // Length prefix: place 7 bits at 7*index, saturate on bits past the counter
  assign len_shift = {varint_index, 3'b000} - {3'b000, varint_index};
  assign len_wide  = {{(WIDE_W-7){1'b0}}, pay} << len_shift;
  assign len_over  = |len_wide[WIDE_W-1:LENGTH_BITS];
  assign len_new   = len_over ? '1 : (length_accum | len_wide[LENGTH_BITS-1:0]);
  assign left_dec  = (bytes_left != '0) ? bytes_left - LENGTH_BITS'(1) : bytes_left;

  // Next parse state for the byte on rec_in
  always_comb begin
    phase_next        = phase;
    key_accum_next    = key_accum;
    key_too_big_next  = key_too_big;
    wire_type_next    = wire_type;
    varint_index_next = varint_index;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    failed_next       = failed;
    key_ended         = 1'b0;
    if (!failed) begin
      unique case (phase)
        PH_KEY: begin
          case (varint_index)
            4'd0: begin
              wire_type_next = pay[2:0];
              key_accum_next = {25'b0, pay[6:3]};
            end
            4'd1: key_accum_next = key_accum | {18'b0, pay, 4'b0};
            4'd2: key_accum_next = key_accum | {11'b0, pay, 11'b0};
            4'd3: key_accum_next = key_accum | {4'b0, pay, 18'b0};
            4'd4: begin
              key_accum_next = key_accum | {pay[3:0], 25'b0};
              if (pay[6:4] != 3'b0) key_too_big_next = 1'b1;
            end
            default: begin
              if (pay != 7'b0) key_too_big_next = 1'b1;
            end
          endcase
          varint_index_next = idx_inc;
          if (!more) begin
            key_ended = 1'b1;
            varint_index_next = 4'd0;
            if (key_too_big_next || key_accum_next == '0 ||
                key_accum_next > max_field_number) begin
              failed_next = 1'b1;
            end else begin
              case (wire_type_next)
                WT_VARINT: phase_next = PH_VARINT;
                WT_FIXED64: begin
                  phase_next = PH_SKIP;
                  bytes_left_next = LENGTH_BITS'(8);
                end
                WT_LEN: begin
                  phase_next = PH_LENGTH;
                  length_accum_next = '0;
                end
                WT_FIXED32: begin
                  phase_next = PH_SKIP;
                  bytes_left_next = LENGTH_BITS'(4);
                end
                default: failed_next = 1'b1;
              endcase
            end
          end
        end
        PH_VARINT: begin
          if (!more) begin
            phase_next = PH_KEY;
            key_accum_next = '0;
            key_too_big_next = 1'b0;
          end
        end
        PH_LENGTH: begin
          length_accum_next = len_new;
          varint_index_next = idx_inc;
          if (!more) begin
            varint_index_next = 4'd0;
            if (len_new == '0) begin
              phase_next = PH_KEY;
              key_accum_next = '0;
              key_too_big_next = 1'b0;
            end else begin
              bytes_left_next = len_new;
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_KEY;
            key_accum_next = '0;
            key_too_big_next = 1'b0;
          end
        end
      endcase
    end
  end

  // Verdict for a record ending on this byte
  assign ok_now = !failed_next && !key_ended && phase_next == PH_KEY &&
                  varint_index_next == 4'd0;

  // Parse state registers; a last byte returns to the start of a record
  always_ff @(posedge clk) begin
    if (rst || (in_fire && rec_in.last_byte)) begin
      phase        <= PH_KEY;
      key_accum    <= '0;
      key_too_big  <= 1'b0;
      wire_type    <= 3'd0;
      varint_index <= 4'd0;
      length_accum <= '0;
      bytes_left   <= '0;
      failed       <= 1'b0;
    end else if (in_fire) begin
      phase        <= phase_next;
      key_accum    <= key_accum_next;
      key_too_big  <= key_too_big_next;
      wire_type    <= wire_type_next;
      varint_index <= varint_index_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      failed       <= failed_next;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && rec_in.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rec_in.last_byte) begin
      out_ok <= ok_now;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_field_number <= '1;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_FIELD) begin
      max_field_number <= pwdata[FIELD_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_FIELD) ? {{(32-FIELD_BITS){1'b0}}, max_field_number}
                                           : 32'd0;

  // A verdict appears only after a last byte was taken
  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire && rec_in.last_byte))
    else $error("verdict without a last byte");

  // No byte is taken while an unread verdict blocks the output
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !verdict.ready) |-> !rec_in.ready)
    else $error("input taken while verdict stalled");

  // A counted skip always has bytes left to skip
  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> bytes_left != '0)
    else $error("skip phase with zero count");

  // Varint index runs only inside a key or a length prefix
  a_index_phase: assert property (@(posedge clk) disable iff (rst)
    varint_index != 4'd0 |-> (phase == PH_KEY || phase == PH_LENGTH))
    else $error("varint index outside a varint");

endmodule

// ----- bench/protobuf_wire_validator_tb.sv -----
`timescale 1ns / 1ps

module protobuf_wire_validator_tb
  import pbwv_pkg::*;
;

  localparam logic [FIELD_BITS-1:0] FIELD_ALL = '1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 rx_ready = 1'b0;

  pbwv_in_if  rec_if ();
  pbwv_out_if vd_if ();

  assign vd_if.ready = rx_ready;

  protobuf_wire_validator u_top (
    .clk     (clk),
    .rst     (rst),
    .rec_in  (rec_if),
    .verdict (vd_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Parser state mirrored by the predictor
  logic [FIELD_BITS-1:0] max_field;
  phase_t                rec_phase;
  logic [FIELD_BITS-1:0] rec_key;
  logic                  rec_big;
  logic [2:0]            rec_wt;
  logic [3:0]            rec_idx;
  logic [31:0]           rec_len;
  logic [31:0]           rec_left;
  logic                  rec_failed;

  logic       verdict_q[$];
  logic [7:0] rec_bytes[$];

  // Pacing controls
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int tx_burst = 0;
  int rx_run = 0;
  bit rx_level = 1'b0;

  int  bytes_sent = 0;
  int  records_sent = 0;
  int  verdicts_seen = 0;
  int  n_accept = 0;
  int  n_reject = 0;
  int  config_writes = 0;
  int  err_count = 0;
  logic want_ok;

  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void restart_key();
    rec_phase = PH_KEY;
    rec_key = '0;
    rec_big = 1'b0;
  endfunction

  function automatic void clear_record();
    restart_key();
    rec_wt = '0;
    rec_idx = '0;
    rec_len = '0;
    rec_left = '0;
    rec_failed = 1'b0;
  endfunction

  // Advance the parse state by one byte; queue a verdict on the last byte
  function automatic void predict_byte(input logic [7:0] b, input logic is_last);
    logic [6:0]  p;
    logic        more;
    logic        key_end;
    logic [63:0] wide;
    int          s;
    p = b[6:0];
    more = b[7];
    key_end = 1'b0;
    if (!rec_failed) begin
      case (rec_phase)
        PH_KEY: begin
          if (rec_idx == 0) begin
            rec_wt = p[2:0];
            rec_key = FIELD_BITS'(p >> 3);
          end else begin
            s = 7 * rec_idx - 3;
            if (s >= FIELD_BITS) begin
              if (p != 0) rec_big = 1'b1;
            end else begin
              wide = 64'(p) << s;
              rec_key = rec_key | wide[FIELD_BITS-1:0];
              if ((64'(p) >> (FIELD_BITS - s)) != 0) rec_big = 1'b1;
            end
          end
          if (rec_idx != IDX_MAX) rec_idx++;
          if (!more) begin
            key_end = 1'b1;
            rec_idx = '0;
            if (rec_big || rec_key == 0 || rec_key > max_field) begin
              rec_failed = 1'b1;
            end else begin
              case (rec_wt)
                WT_VARINT: rec_phase = PH_VARINT;
                WT_FIXED64: begin
                  rec_phase = PH_SKIP;
                  rec_left = 32'd8;
                end
                WT_LEN: begin
                  rec_phase = PH_LENGTH;
                  rec_len = '0;
                end
                WT_FIXED32: begin
                  rec_phase = PH_SKIP;
                  rec_left = 32'd4;
                end
                default: rec_failed = 1'b1;
              endcase
            end
          end
        end
        PH_VARINT: begin
          if (!more) restart_key();
        end
        PH_LENGTH: begin
          s = 7 * rec_idx;
          // lengths past 32 bits saturate
          if (s >= 32) begin
            if (p != 0) rec_len = '1;
          end else if ((32 - s) < 7 && (32'(p) >> (32 - s)) != 0) begin
            rec_len = '1;
          end else begin
            wide = 64'(p) << s;
            rec_len = rec_len | wide[31:0];
          end
          if (rec_idx != IDX_MAX) rec_idx++;
          if (!more) begin
            rec_idx = '0;
            if (rec_len == 0) begin
              restart_key();
            end else begin
              rec_left = rec_len;
              rec_phase = PH_SKIP;
            end
          end
        end
        default: begin
          if (rec_left > 0) rec_left--;
          if (rec_left == 0) restart_key();
        end
      endcase
    end
    if (is_last) begin
      verdict_q.push_back(!rec_failed && !key_end && rec_phase == PH_KEY && rec_idx == 0);
      clear_record();
    end
  endfunction

  // Verdict checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
      rx_run = 0;
      rx_level = 1'b0;
    end else begin
      if (vd_if.valid && vd_if.ready) begin
        if (verdict_q.size() == 0) begin
          log_error($sformatf("verdict %0b with no record pending", vd_if.record_ok));
        end else begin
          want_ok = verdict_q.pop_front();
          verdicts_seen++;
          if (want_ok) n_accept++;
          else n_reject++;
          if (vd_if.record_ok !== want_ok)
            log_error($sformatf("record %0d: record_ok expected %0b, got %0b",
                                verdicts_seen, want_ok, vd_if.record_ok));
        end
      end
      if (rx_run == 0) begin
        rx_level = ~rx_level;
        rx_run = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 5);
      end else begin
        rx_run--;
      end
      rx_ready <= rx_steady || rx_level;
    end
  end

  // One byte beat, sent in bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 16);
      gap = tx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        rec_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst--;
    rec_if.valid <= 1'b1;
    rec_if.data_byte <= b;
    rec_if.last_byte <= is_last;
    @(posedge clk);
    while (!rec_if.ready) @(posedge clk);
    bytes_sent++;
    predict_byte(b, is_last);
  endtask

  task automatic send_record();
    int n;
    n = rec_bytes.size();
    for (int i = 0; i < n; i++) send_byte(rec_bytes[i], i == n - 1);
    records_sent++;
    rec_bytes.delete();
  endtask

  // Stop sending and let every pending verdict come out
  task automatic wait_verdicts_done(input int settle);
    int guard;
    guard = 0;
    rec_if.valid <= 1'b0;
    while (verdict_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (verdict_q.size() != 0) begin
      log_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
      verdict_q.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  // Register write: setup beat then access beat, then read back
  task automatic write_max_field(input logic [FIELD_BITS-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MAX_FIELD;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_field = v;
    config_writes++;
    @(posedge clk);
    if (prdata !== 32'(v))
      log_error($sformatf("max_field_number read expected %0d, got %0d", v, prdata));
  endtask

  // Varint with optional redundant zero continuation bytes
  function automatic void put_varint(input logic [63:0] v, input int pad);
    logic [63:0] r;
    int          extra;
    r = v;
    extra = pad;
    while ((r >> 7) != 0 || extra > 0) begin
      rec_bytes.push_back({1'b1, r[6:0]});
      if ((r >> 7) == 0) extra--;
      r = r >> 7;
    end
    rec_bytes.push_back({1'b0, r[6:0]});
  endfunction

  function automatic int rand_pad();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  // Key plus a payload shaped by the wire type
  function automatic void put_tag(input logic [63:0] field, input logic [2:0] wt,
                                  input int pad);
    int n;
    put_varint((field << 3) | 64'(wt), pad);
    case (wt)
      WT_VARINT: put_varint({$urandom, $urandom} >> $urandom_range(0, 63), rand_pad());
      WT_FIXED64: repeat (8) rec_bytes.push_back(8'($urandom));
      WT_FIXED32: repeat (4) rec_bytes.push_back(8'($urandom));
      WT_LEN: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
        put_varint(64'(n), rand_pad());
        repeat (n) rec_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] good_field();
    case ($urandom_range(0, 5))
      0: return 64'd1;
      1: return 64'(max_field);
      2: return 64'($urandom_range(1, 32'(max_field)));
      default: return 64'($urandom_range(1, (max_field < 15) ? 32'(max_field) : 15));
    endcase
  endfunction

  function automatic logic [63:0] bad_field();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return 64'(max_field) + 64'd1;
      2: return (64'd1 << FIELD_BITS) | 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [2:0] good_wt();
    case ($urandom_range(0, 3))
      0: return WT_VARINT;
      1: return WT_FIXED64;
      2: return WT_LEN;
      default: return WT_FIXED32;
    endcase
  endfunction

  function automatic logic [2:0] bad_wt();
    logic [2:0] w;
    w = 3'($urandom_range(3, 6));
    if (w >= 3'd5) w++;
    return w;
  endfunction

  // Mostly well-formed records, the rest cut, corrupted, bad keys or noise
  function automatic void build_record();
    int kind;
    int cut;
    int pos;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 8)) rec_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) put_tag(good_field(), good_wt(), rand_pad());
      if (kind >= 80) begin
        case ($urandom_range(0, 2))
          0: put_tag(bad_field(), good_wt(), rand_pad());
          1: put_tag(good_field(), bad_wt(), rand_pad());
          default: begin
            // length prefix past 32 bits
            put_varint((good_field() << 3) | 64'(WT_LEN), 0);
            put_varint({$urandom, $urandom} | 64'h1_0000_0000, 0);
            repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom));
          end
        endcase
        if ($urandom_range(0, 1)) put_tag(good_field(), good_wt(), 0);
      end else if (kind >= 70) begin
        pos = $urandom_range(0, rec_bytes.size() - 1);
        rec_bytes[pos] = 8'($urandom);
      end else if (kind >= 55 && rec_bytes.size() > 1) begin
        cut = $urandom_range(1, rec_bytes.size() - 1);
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      end
    end
  endfunction

  // Each wire type, a multi-byte varint and a zero length prefix
  task automatic test_wire_types();
    rec_bytes = '{8'h08, 8'h96, 8'h01};
    send_record();
    put_tag(64'd2, WT_FIXED64, 0);
    send_record();
    put_tag(64'd3, WT_FIXED32, 0);
    send_record();
    rec_bytes = '{8'h0A, 8'h00};
    send_record();
    // bad wire type after a length run
    rec_bytes = '{8'h12, 8'h01, 8'hFF, 8'h1B};
    send_record();
  endtask

  // Field number limits, too-wide keys and records ending at a key
  task automatic test_key_checks();
    rec_bytes = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h00};
    send_record();
    rec_bytes = '{8'h00, 8'h00};
    send_record();
    rec_bytes = '{8'h08};
    send_record();
    rec_bytes = '{8'h88};
    send_record();
    wait_verdicts_done(2);
    write_max_field(29'd1);
    rec_bytes = '{8'h10, 8'h00};
    send_record();
    rec_bytes = '{8'h08, 8'h00};
    send_record();
    wait_verdicts_done(2);
    write_max_field('0);
    rec_bytes = '{8'h08, 8'h00};
    send_record();
    wait_verdicts_done(2);
    write_max_field(FIELD_ALL);
  endtask

  // Saturating length prefix, short and exact payload runs
  task automatic test_length_prefix();
    rec_bytes = '{8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_record();
    rec_bytes = '{8'h0A, 8'h02, 8'h00};
    send_record();
    rec_bytes = '{8'h0A, 8'h01, 8'h5A};
    send_record();
  endtask

  // Random records over several limit settings and pacing modes
  task automatic test_random_records();
    logic [FIELD_BITS-1:0] limits[4];
    int target;
    limits[0] = FIELD_ALL;
    limits[1] = FIELD_BITS'($urandom_range(16, 5000));
    limits[2] = 29'd7;
    limits[3] = 29'd1;
    for (int ph = 0; ph < 4; ph++) begin
      wait_verdicts_done(2);
      write_max_field(limits[ph]);
      tx_steady = (ph == 0);
      rx_steady = (ph == 0);
      target = bytes_sent + 300;
      while (bytes_sent < target) begin
        build_record();
        send_record();
        // sender holds off until the block has drained
        if ($urandom_range(0, 29) == 0) wait_verdicts_done(1);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rec_if.valid <= 1'b0;
    rec_if.data_byte <= '0;
    rec_if.last_byte <= 1'b0;
    max_field = FIELD_ALL;
    clear_record();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_wire_types();
    test_key_checks();
    test_length_prefix();
    test_random_records();
    wait_verdicts_done(10);

    $display("Covered %0d bytes in %0d records, %0d verdicts checked (%0d ok, %0d rejected)",
             bytes_sent, records_sent, verdicts_seen, n_accept, n_reject);
    $display("Wrote max_field_number %0d times; %0d errors", config_writes, err_count);
    if (err_count == 0) begin
      $display("protobuf_wire_validator_tb OK");
    end else begin
      $display("protobuf_wire_validator_tb NOT OK");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Timeout: stuck with %0d verdicts pending", verdict_q.size());
    $display("protobuf_wire_validator_tb NOT OK");
    $finish;
  end

endmodule
